@@ hw/rtl/bdq_pkg.sv @@
// Shared types, constants and helper functions of the bilinear downscale and quantize unit.
// Used by the channel interfaces, the quantizer and the top level. No dependencies.
package bdq_pkg;

    // Sizes of the line buffer, the fixed-point coordinates and the ports.
    localparam int MAX_WIDTH  = 256;
    localparam int FRAC_BITS  = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 9;
    localparam int STEP_W     = 24;
    localparam int COORD_W    = DIM_W + STEP_W + 1;
    localparam int IPART_W    = COORD_W - FRAC_BITS;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;
    localparam int QUANT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_MAX    = 256;

    // Smallest step, one in Q16; smaller step settings are raised to it.
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_STEP_X     = 3'd4,
        REG_STEP_Y     = 3'd5,
        REG_QUANT_GAIN = 3'd6,
        REG_QUANT_BIAS = 3'd7
    } cfg_reg_t;

    // Steps of the per-pixel sequencer.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROWS,
        S_XMUL,
        S_HMUL,
        S_VMUL,
        S_QMUL,
        S_QADD,
        S_QOUT,
        S_FIN
    } state_t;

    // Lower and upper neighbor index of a source coordinate.
    typedef struct packed {
        logic [DIM_W-1:0] p0;
        logic [DIM_W-1:0] p1;
    } split_t;

    // Stage enables of the quantizer.
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } quant_ctrl_t;

    // Limits a frame dimension to 1..DIM_MAX, or to 0..DIM_MAX when zero is allowed.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic allow_zero);
        logic [DIM_W-1:0] r;
        begin
            if (v > DIM_W'(DIM_MAX))
                r = DIM_W'(DIM_MAX);
            else if (v == '0 && !allow_zero)
                r = DIM_W'(1);
            else
                r = v;
            return r;
        end
    endfunction

    // Integer part of a coordinate split into the two neighbors, both clamped to n-1.
    function automatic split_t split_coord(input logic [IPART_W-1:0] ipart,
                                           input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0]   last;
        logic [IPART_W:0]   nxt;
        split_t             s;
        begin
            last = n - DIM_W'(1);
            nxt  = {1'b0, ipart} + (IPART_W+1)'(1);
            s.p0 = (ipart >= IPART_W'(last)) ? last : ipart[DIM_W-1:0];
            s.p1 = (nxt >= (IPART_W+1)'(last)) ? last : nxt[DIM_W-1:0];
            return s;
        end
    endfunction

endpackage

@@ hw/rtl/bdq_pixel_if.sv @@
// Input channel of the unit: one grayscale pixel per transfer with a frame start mark.
// Depends on bdq_pkg.
interface bdq_pixel_if;
    import bdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

@@ hw/rtl/bdq_result_if.sv @@
// Output channel of the unit: one quantized output pixel with its position per transfer.
// Depends on bdq_pkg.
interface bdq_result_if;
    import bdq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_done;

    modport source (output valid, output value, output out_row, output out_col,
                    output frame_done, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input frame_done, output ready);
endinterface

@@ hw/rtl/bdq_quant.sv @@
// Two-stage quantizer: pixel times gain plus bias, scaled by 2^-16 toward zero, int8 saturated.
// Depends on bdq_pkg.
module bdq_quant (
    input  logic                          clk,
    input  bdq_pkg::quant_ctrl_t          ctrl,
    input  logic [bdq_pkg::PIX_W-1:0]     pix,
    input  logic signed [bdq_pkg::QUANT_W-1:0] gain,
    input  logic signed [bdq_pkg::QUANT_W-1:0] bias,
    output logic signed [bdq_pkg::PIX_W-1:0]   value
);
    import bdq_pkg::*;

    localparam int MUL_W = PIX_W + 1 + QUANT_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int Q_W   = SUM_W - FRAC_BITS;

    logic signed [MUL_W-1:0] mul_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] adj;
    logic signed [Q_W-1:0]   q;

    // Product and offset stages.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            mul_reg <= $signed({1'b0, pix}) * gain;
        end
        if (ctrl.add_en)
        begin
            sum_reg <= mul_reg + bias;
        end
    end

    // A negative sum is biased up so that the arithmetic shift truncates toward zero.
    assign adj = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
    assign q   = $signed(adj[SUM_W-1:FRAC_BITS]);

    // Saturation to the int8 range.
    always_comb
    begin
        if (q > Q_W'(127))
            value = 8'sd127;
        else if (q < -Q_W'(128))
            value = -8'sd128;
        else
            value = $signed(q[PIX_W-1:0]);
    end

endmodule

@@ hw/rtl/bilinear_downscale_quantize_unit.sv @@
// Bilinear downscaler for a raster stream of 8-bit grayscale pixels with int8 quantized output.
// Depends on bdq_pkg, bdq_pixel_if, bdq_result_if and bdq_quant.
//
// The unit takes one pixel at a time and keeps the previous input row in a 256 x 8 line buffer
// that is read when a pixel is taken and written back in the next cycle. An output pixel is sent
// when its lower-right source neighbor arrives; on the last input row two output rows may be
// due at the same pixel, and at most two results leave per input pixel. A pixel with no output
// row due passes through transfer, row check and finish. When rows are due, each output column
// visited adds a source x multiply and a neighbor check, and each result a vertical blend, a
// quantizer multiply, a bias add and an output load; the column loop ends with one more source
// x multiply, or with that and a neighbor check when the next column's neighbor lies further
// right. The output load waits while the sink holds the output register full. The line buffer
// holds garbage after reset; the first row of a frame never needs it. Configuration is written
// through wr_en, wr_index and wr_data; the user must write it only while no pixel is in flight,
// which the unit itself does not enforce, and it takes effect at the next pixel.
module bilinear_downscale_quantize_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bdq_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [bdq_pkg::CFG_DATA_W-1:0]    wr_data,
    bdq_pixel_if.sink                         pixels,
    bdq_result_if.source                      results
);
    import bdq_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]          in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic [STEP_W-1:0]         step_x_reg, step_y_reg;
    logic signed [QUANT_W-1:0] quant_gain_reg, quant_bias_reg;

    // Sequencer and position state.
    state_t             state_reg, state_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [POS_W-1:0]   in_row_reg, in_row_next;
    logic [DIM_W-1:0]   nro_reg, nro_next;
    logic [DIM_W-1:0]   nco_reg, nco_next;
    logic [PIX_W-1:0]   left_reg, left_next;
    logic [PIX_W-1:0]   ul_reg, ul_next;
    logic [1:0]         nrows_reg, nrows_next;
    logic               k_reg, k_next;
    logic [1:0]         count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    // Per-pixel working registers.
    logic [PIX_W-1:0]          cur_reg, cur_next;
    logic [COORD_W-1:0]        yprod_reg, yprod_next;
    logic [COORD_W-1:0]        xprod_reg, xprod_next;
    logic                      flat0_reg, flat0_next, flat1_reg, flat1_next;
    logic [FRAC_BITS-1:0]      fy0_reg, fy0_next, fy1_reg, fy1_next;
    logic signed [STEP_W:0]    hb_reg, hb_next, ht_reg, ht_next;
    logic [PIX_W-1:0]          pix_reg, pix_next;
    logic signed [PIX_W-1:0]   value_reg, value_next;
    logic [POS_W-1:0]          orow_reg, orow_next, ocol_reg, ocol_next;
    logic                      done_reg, done_next;

    // Line buffer.
    logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  mem_rdata_reg;
    logic              mem_re;
    logic [COL_W-1:0]  mem_raddr;
    logic              mem_we;

    // Effective configuration.
    logic [DIM_W-1:0]  w_eff, h_eff, ow_eff, oh_eff;
    logic [STEP_W-1:0] sx_eff, sy_eff;

    // Combinational datapath.
    logic                     accept, out_free;
    logic                     fs;
    logic [DIM_W-1:0]         nro_sel;
    logic [COORD_W-1:0]       y1c;
    split_t                   sp_y0, sp_y1, sp_x;
    logic                     due0, due1;
    logic [DIM_W:0]           nro_inc;
    logic [FRAC_BITS-1:0]     fx, fy_sel;
    logic                     x_flat;
    logic [PIX_W-1:0]         v10, vu0;
    logic signed [PIX_W:0]    diff_b, diff_t;
    logic signed [STEP_W+1:0] hb_prod, ht_prod;
    logic signed [STEP_W:0]   top_sel;
    logic signed [STEP_W+1:0] vdiff;
    logic signed [STEP_W+FRAC_BITS+2:0] vprod;
    logic signed [STEP_W+FRAC_BITS+3:0] vsum;
    logic [DIM_W-1:0]         row_sel;
    logic [DIM_W:0]           col_inc, row_inc;
    logic [DIM_W-1:0]         nro_mid, nco_mid;
    quant_ctrl_t              qctrl;
    logic signed [PIX_W-1:0]  q_value;

    assign w_eff  = clamp_dim(in_width_reg, 1'b0);
    assign h_eff  = clamp_dim(in_height_reg, 1'b0);
    assign ow_eff = clamp_dim(out_width_reg, 1'b1);
    assign oh_eff = clamp_dim(out_height_reg, 1'b1);
    assign sx_eff = (step_x_reg < STEP_ONE) ? STEP_ONE : step_x_reg;
    assign sy_eff = (step_y_reg < STEP_ONE) ? STEP_ONE : step_y_reg;

    // Handshakes.
    assign pixels.ready = (state_reg == S_IDLE);
    assign accept       = pixels.valid && pixels.ready;
    assign out_free     = !out_valid_reg || results.ready;
    assign fs           = pixels.frame_start;
    assign nro_sel      = fs ? '0 : nro_reg;

    // Output rows due at this pixel.
    assign y1c     = yprod_reg + COORD_W'(sy_eff);
    assign sp_y0   = split_coord(yprod_reg[COORD_W-1:FRAC_BITS], h_eff);
    assign sp_y1   = split_coord(y1c[COORD_W-1:FRAC_BITS], h_eff);
    assign nro_inc = {1'b0, nro_reg} + (DIM_W+1)'(1);
    assign due0    = (nro_reg < oh_eff) && (sp_y0.p1 == {1'b0, in_row_reg});
    assign due1    = due0 && ({1'b0, in_row_reg} == h_eff - DIM_W'(1))
                     && (nro_inc < {1'b0, oh_eff}) && (sp_y1.p1 == {1'b0, in_row_reg});

    // Horizontal blend of the lower and upper source rows.
    assign sp_x    = split_coord(xprod_reg[COORD_W-1:FRAC_BITS], w_eff);
    assign fx      = xprod_reg[FRAC_BITS-1:0];
    assign x_flat  = (sp_x.p0 == sp_x.p1);
    assign v10     = x_flat ? cur_reg : left_reg;
    assign vu0     = x_flat ? mem_rdata_reg : ul_reg;
    assign diff_b  = $signed({1'b0, cur_reg}) - $signed({1'b0, v10});
    assign diff_t  = $signed({1'b0, mem_rdata_reg}) - $signed({1'b0, vu0});
    assign hb_prod = diff_b * $signed({1'b0, fx});
    assign ht_prod = diff_t * $signed({1'b0, fx});

    // Vertical blend for the current output row.
    assign fy_sel  = k_reg ? fy1_reg : fy0_reg;
    assign top_sel = (k_reg ? flat1_reg : flat0_reg) ? hb_reg : ht_reg;
    assign vdiff   = hb_reg - top_sel;
    assign vprod   = vdiff * $signed({1'b0, fy_sel});
    assign vsum    = $signed({top_sel, {FRAC_BITS{1'b0}}}) + vprod;
    assign row_sel = k_reg ? nro_inc[DIM_W-1:0] : nro_reg;

    // Input position advance at the end of a pixel.
    assign col_inc = {2'b0, in_col_reg} + (DIM_W+1)'(1);
    assign row_inc = {2'b0, in_row_reg} + (DIM_W+1)'(1);

    // Line buffer: read on the accepting edge, written back during the row check that follows.
    assign mem_re    = accept;
    assign mem_raddr = fs ? '0 : in_col_reg;
    assign mem_we    = (state_reg == S_ROWS);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[in_col_reg] <= cur_reg;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= line_mem[mem_raddr];
        end
    end

    // Quantizer.
    assign qctrl.mul_en = (state_reg == S_QMUL);
    assign qctrl.add_en = (state_reg == S_QADD);

    bdq_quant u_quant (
        .clk   (clk),
        .ctrl  (qctrl),
        .pix   (pix_reg),
        .gain  (quant_gain_reg),
        .bias  (quant_bias_reg),
        .value (q_value)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= DIM_W'(176);
            in_height_reg  <= DIM_W'(144);
            out_width_reg  <= DIM_W'(48);
            out_height_reg <= DIM_W'(48);
            step_x_reg     <= STEP_W'(240298);
            step_y_reg     <= STEP_W'(196608);
            quant_gain_reg <= '0;
            quant_bias_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_IN_WIDTH:   in_width_reg   <= wr_data[DIM_W-1:0];
                REG_IN_HEIGHT:  in_height_reg  <= wr_data[DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= wr_data[DIM_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= wr_data[DIM_W-1:0];
                REG_STEP_X:     step_x_reg     <= wr_data[STEP_W-1:0];
                REG_STEP_Y:     step_y_reg     <= wr_data[STEP_W-1:0];
                REG_QUANT_GAIN: quant_gain_reg <= $signed(wr_data[QUANT_W-1:0]);
                REG_QUANT_BIAS: quant_bias_reg <= $signed(wr_data[QUANT_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Sequencer: next state and datapath loads.
    always_comb
    begin
        state_next     = state_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        nro_next       = nro_reg;
        nco_next       = nco_reg;
        left_next      = left_reg;
        ul_next        = ul_reg;
        nrows_next     = nrows_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !results.ready;
        cur_next       = cur_reg;
        yprod_next     = yprod_reg;
        xprod_next     = xprod_reg;
        flat0_next     = flat0_reg;
        flat1_next     = flat1_reg;
        fy0_next       = fy0_reg;
        fy1_next       = fy1_reg;
        hb_next        = hb_reg;
        ht_next        = ht_reg;
        pix_next       = pix_reg;
        value_next     = value_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        done_next      = done_reg;
        nro_mid        = nro_reg;
        nco_mid        = nco_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next    = pixels.pixel;
                    in_col_next = fs ? '0 : in_col_reg;
                    in_row_next = fs ? '0 : in_row_reg;
                    nro_next    = nro_sel;
                    nco_next    = fs ? '0 : nco_reg;
                    yprod_next  = COORD_W'(nro_sel) * COORD_W'(sy_eff);
                    state_next  = S_ROWS;
                end
            end
            S_ROWS:
            begin
                nrows_next = due0 ? (due1 ? 2'd2 : 2'd1) : 2'd0;
                flat0_next = (sp_y0.p0 == sp_y0.p1);
                flat1_next = (sp_y1.p0 == sp_y1.p1);
                fy0_next   = yprod_reg[FRAC_BITS-1:0];
                fy1_next   = y1c[FRAC_BITS-1:0];
                count_next = '0;
                state_next = due0 ? S_XMUL : S_FIN;
            end
            S_XMUL:
            begin
                if (nco_reg >= ow_eff)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    xprod_next = COORD_W'(nco_reg) * COORD_W'(sx_eff);
                    state_next = S_HMUL;
                end
            end
            S_HMUL:
            begin
                if (sp_x.p1 != {1'b0, in_col_reg})
                begin
                    state_next = S_FIN;
                end
                else if (count_reg >= 2'd2)
                begin
                    nco_next   = nco_reg + DIM_W'(1);
                    state_next = S_XMUL;
                end
                else
                begin
                    hb_next    = $signed({1'b0, v10, {FRAC_BITS{1'b0}}})
                                 + $signed(hb_prod[STEP_W:0]);
                    ht_next    = $signed({1'b0, vu0, {FRAC_BITS{1'b0}}})
                                 + $signed(ht_prod[STEP_W:0]);
                    k_next     = 1'b0;
                    state_next = S_VMUL;
                end
            end
            S_VMUL:
            begin
                pix_next   = (vsum[STEP_W+FRAC_BITS+3:2*FRAC_BITS+PIX_W] != '0)
                             ? {PIX_W{1'b1}} : vsum[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
                state_next = S_QMUL;
            end
            S_QMUL:
            begin
                state_next = S_QADD;
            end
            S_QADD:
            begin
                state_next = S_QOUT;
            end
            S_QOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = q_value;
                    orow_next      = row_sel[POS_W-1:0];
                    ocol_next      = nco_reg[POS_W-1:0];
                    done_next      = (row_sel == oh_eff - DIM_W'(1))
                                     && (nco_reg == ow_eff - DIM_W'(1));
                    count_next     = count_reg + 2'd1;
                    if (!k_reg && nrows_reg == 2'd2 && count_reg == 2'd0)
                    begin
                        k_next     = 1'b1;
                        state_next = S_VMUL;
                    end
                    else
                    begin
                        nco_next   = nco_reg + DIM_W'(1);
                        state_next = S_XMUL;
                    end
                end
            end
            S_FIN:
            begin
                // Row advance once all columns of the due rows are out.
                if (nrows_reg != 2'd0 && nco_reg >= ow_eff)
                begin
                    nro_mid = nro_reg + DIM_W'(nrows_reg);
                    nco_mid = '0;
                end
                nro_next  = nro_mid;
                nco_next  = nco_mid;
                ul_next   = mem_rdata_reg;
                left_next = cur_reg;
                if (col_inc >= {1'b0, w_eff})
                begin
                    in_col_next = '0;
                    if (row_inc >= {1'b0, h_eff})
                    begin
                        in_row_next = '0;
                        nro_next    = '0;
                        nco_next    = '0;
                    end
                    else
                    begin
                        in_row_next = row_inc[POS_W-1:0];
                    end
                end
                else
                begin
                    in_col_next = col_inc[COL_W-1:0];
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            nro_reg       <= '0;
            nco_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            nrows_reg     <= '0;
            k_reg         <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            nro_reg       <= nro_next;
            nco_reg       <= nco_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            nrows_reg     <= nrows_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        yprod_reg <= yprod_next;
        xprod_reg <= xprod_next;
        flat0_reg <= flat0_next;
        flat1_reg <= flat1_next;
        fy0_reg   <= fy0_next;
        fy1_reg   <= fy1_next;
        hb_reg    <= hb_next;
        ht_reg    <= ht_next;
        pix_reg   <= pix_next;
        value_reg <= value_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        done_reg  <= done_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.value      = value_reg;
    assign results.out_row    = orow_reg;
    assign results.out_col    = ocol_reg;
    assign results.frame_done = done_reg;

    // A taken pixel always starts with the row check that writes the line buffer.
    a_accept_rows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ROWS))
        else $error("pixel transfer not followed by the row check");

    // No more than two results leave for one input pixel.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QOUT) |-> (count_reg < 2'd2))
        else $error("third result for one input pixel");

    // The second row is only blended when two rows are due.
    a_row_sel: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_VMUL) && k_reg) |-> (nrows_reg == 2'd2))
        else $error("second row blended with one row due");

    // When the output register is free, a result is always loaded into it and shown as valid.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_QOUT) && out_free) |=> out_valid_reg)
        else $error("result load lost");

    // The column loop is only entered with at least one output row due.
    a_rows_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XMUL) |-> (nrows_reg != 2'd0))
        else $error("column loop entered without a due row");

endmodule

@@ tb/tb_bilinear_downscale_quantize_unit.sv @@
// Self-checking testbench of the bilinear downscale and quantize unit.
// A scoreboard class predicts every output pixel from the accepted input pixels and register
// writes; depends on bdq_pkg, bdq_pixel_if, bdq_result_if and the unit itself.

// Predicts the downscaled, quantized output stream and checks the transfers that leave the unit.
class downscale_scoreboard;
    typedef struct {
        logic signed [7:0] value;
        logic [7:0]        out_row;
        logic [7:0]        out_col;
        logic              frame_done;
    } outpix_t;

    bit [8:0]         in_w, in_h, o_w, o_h;
    bit [23:0]        stp_x, stp_y;
    bit [31:0]        gain, bias;
    byte unsigned     line_buf[256];
    int unsigned      col, row, nxt_row, nxt_col;
    byte unsigned     left_px, upleft_px;
    outpix_t          pending[$];
    int               errors;

    function new();
        in_w = 176; in_h = 144; o_w = 48; o_h = 48;
        stp_x = 240298; stp_y = 196608; gain = 0; bias = 0;
        foreach (line_buf[i]) line_buf[i] = 0;
        col = 0; row = 0; nxt_row = 0; nxt_col = 0;
        left_px = 0; upleft_px = 0; errors = 0;
    endfunction

    function void set_reg(bdq_pkg::cfg_reg_t idx, bit [31:0] d);
        case (idx)
            bdq_pkg::REG_IN_WIDTH:   in_w = d[8:0];
            bdq_pkg::REG_IN_HEIGHT:  in_h = d[8:0];
            bdq_pkg::REG_OUT_WIDTH:  o_w = d[8:0];
            bdq_pkg::REG_OUT_HEIGHT: o_h = d[8:0];
            bdq_pkg::REG_STEP_X:     stp_x = d[23:0];
            bdq_pkg::REG_STEP_Y:     stp_y = d[23:0];
            bdq_pkg::REG_QUANT_GAIN: gain = d;
            default:                 bias = d;
        endcase
    endfunction

    function int unsigned clip_dim(bit [8:0] v, int unsigned lo);
        return (v < lo) ? lo : ((v > 256) ? 256 : v);
    endfunction

    function longint unsigned step_of(bit [23:0] s);
        return (s < 24'h010000) ? 64'h10000 : longint'(s);
    endfunction

    // Lower and upper neighbor of a coordinate, both clamped to the last index.
    function void neighbors(longint unsigned coord, int unsigned n,
                            output int unsigned p0, output int unsigned p1);
        longint unsigned ip;
        ip = coord >> 16;
        p0 = (ip >= n - 1) ? n - 1 : int'(ip);
        p1 = (ip + 1 >= n - 1) ? n - 1 : int'(ip + 1);
    endfunction

    // Scale, round toward zero and saturate to int8.
    function logic [7:0] quantize(int unsigned pix);
        longint s, q;
        s = longint'(pix) * longint'($signed(gain)) + longint'($signed(bias));
        q = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        return q[7:0];
    endfunction

    // Notes one accepted input pixel and queues the output pixels it completes.
    function void note_pixel(bit [7:0] px, bit fs);
        int unsigned w, h, ow, oh, c, r, old, a, b, nrows, cnt, x0, x1, y0, y1;
        int unsigned v00, v01, v10, v11, pix;
        int unsigned rows[2];
        longint unsigned sx, sy, xc, yc, fx, fy, sum;
        outpix_t o;
        w = clip_dim(in_w, 1); h = clip_dim(in_h, 1);
        ow = clip_dim(o_w, 0); oh = clip_dim(o_h, 0);
        sx = step_of(stp_x); sy = step_of(stp_y);
        nrows = 0; cnt = 0;
        if (fs)
        begin
            col = 0; row = 0; nxt_row = 0; nxt_col = 0;
        end
        c = col; r = row;
        old = line_buf[c];
        // Rows due at this input row; the last row may finish two.
        if (nxt_row < oh)
        begin
            neighbors(longint'(nxt_row) * sy, h, a, b);
            if (b == r)
            begin
                rows[nrows++] = nxt_row;
                if (r == h - 1 && nxt_row + 1 < oh)
                begin
                    neighbors(longint'(nxt_row + 1) * sy, h, a, b);
                    if (b == r) rows[nrows++] = nxt_row + 1;
                end
            end
        end
        // Columns whose lower-right neighbor is this pixel.
        while (nrows > 0 && nxt_col < ow)
        begin
            xc = longint'(nxt_col) * sx;
            neighbors(xc, w, x0, x1);
            if (x1 != c) break;
            for (int k = 0; k < nrows; k++)
            begin
                if (cnt >= 2) continue;
                yc = longint'(rows[k]) * sy;
                fx = xc & 64'hFFFF; fy = yc & 64'hFFFF;
                neighbors(yc, h, y0, y1);
                v11 = px;
                v10 = (x0 == x1) ? px : left_px;
                if (y0 == y1)
                begin
                    v01 = px; v00 = v10;
                end
                else
                begin
                    v01 = old; v00 = (x0 == x1) ? old : upleft_px;
                end
                sum = longint'(v00) * (64'h10000 - fx) * (64'h10000 - fy)
                    + longint'(v01) * fx * (64'h10000 - fy)
                    + longint'(v10) * (64'h10000 - fx) * fy
                    + longint'(v11) * fx * fy;
                sum = sum >> 32;
                pix = (sum > 255) ? 255 : int'(sum);
                o.value = quantize(pix);
                o.out_row = rows[k][7:0];
                o.out_col = nxt_col[7:0];
                o.frame_done = (rows[k] == oh - 1 && nxt_col == ow - 1);
                pending.push_back(o);
                cnt++;
            end
            nxt_col++;
        end
        if (nrows > 0 && nxt_col >= ow)
        begin
            nxt_row += nrows;
            nxt_col = 0;
        end
        upleft_px = old;
        left_px = px;
        line_buf[c] = px;
        // Advance the input position, wrapping at the end of the frame.
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
            begin
                row = 0; nxt_row = 0; nxt_col = 0;
            end
        end
    endfunction

    // Compares one output transfer with the oldest prediction.
    function void check(logic signed [7:0] value, logic [7:0] orow, logic [7:0] ocol,
                        logic done);
        outpix_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected output pixel value=%0d row=%0d col=%0d done=%0b",
                     $time, value, orow, ocol, done);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (value !== e.value)
        begin
            $display("%0t: value expected %0d actual %0d", $time, e.value, value);
            errors++;
        end
        if (orow !== e.out_row)
        begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.out_row, orow);
            errors++;
        end
        if (ocol !== e.out_col)
        begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.out_col, ocol);
            errors++;
        end
        if (done !== e.frame_done)
        begin
            $display("%0t: frame_done expected %0b actual %0b", $time, e.frame_done, done);
            errors++;
        end
    endfunction
endclass

module tb_bilinear_downscale_quantize_unit;
    import bdq_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    pixels_sent;
    int                    stall_left;
    downscale_scoreboard   sb;

    bdq_pixel_if  pix_if ();
    bdq_result_if res_if ();

    bilinear_downscale_quantize_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixels   (pix_if),
        .results  (res_if)
    );

    // Clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Sink side: ready is lowered for random stretches.
    initial
    begin
        res_if.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready = 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // Every output transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check(res_if.value, res_if.out_row, res_if.out_col, res_if.frame_done);
    end

    // Writes one register while the unit is idle.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = d;
        sb.set_reg(idx, d);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic write_all(logic [31:0] iw, logic [31:0] ih, logic [31:0] ow,
                             logic [31:0] oh, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] g, logic [31:0] b);
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_IN_HEIGHT, ih);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_QUANT_GAIN, g);
        write_reg(REG_QUANT_BIAS, b);
    endtask

    // Sends one pixel after an optional gap; called at a falling edge.
    task automatic send_pixel(logic [7:0] px, logic fs, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0)
        begin
            pix_if.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        pix_if.valid = 1'b1;
        pix_if.pixel = px;
        pix_if.frame_start = fs;
        forever
        begin
            @(posedge clk);
            if (pix_if.ready) break;
        end
        sb.note_pixel(px, fs);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Waits until every predicted output has left, then for the unit to settle.
    task automatic drain();
        @(negedge clk);
        pix_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    // One frame of random pixels; a broken frame may stop early, and any frame may restart mid-frame.
    task automatic send_frame(bit broken);
        int n, stop;
        bit gaps;
        n = sb.clip_dim(sb.in_w, 1) * sb.clip_dim(sb.in_h, 1);
        stop = broken ? $urandom_range(1, n) : n;
        gaps = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < stop; i++)
            send_pixel(8'($urandom_range(0, 255)),
                       (i == 0) ? ($urandom_range(0, 4) != 0)
                                : ($urandom_range(0, 199) == 0), gaps);
    endtask

    // Random small frame geometry and quantizer setting.
    task automatic random_config();
        int w, h, ow, oh, sx, sy;
        int unsigned g, b;
        w = $urandom_range(2, 14);
        h = $urandom_range(2, 10);
        ow = $urandom_range(1, w + 2);
        oh = $urandom_range(1, h + 2);
        sx = $urandom_range(65536, ((w << 16) / ow) + 65536);
        sy = $urandom_range(65536, ((h << 16) / oh) + 65536);
        if ($urandom_range(0, 9) == 0) sx = $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0) sy = 24'hFFFFFF;
        if ($urandom_range(0, 3) == 0)
        begin
            g = $urandom();
            b = $urandom();
        end
        else
        begin
            g = $urandom_range(0, 262144) - 131072;
            b = $urandom_range(0, 16777216) - 8388608;
        end
        write_all(w, h, ow, oh, sx, sy, g, b);
    endtask

    // Stimulus: directed settings first, then random phases.
    initial
    begin
        sb = new();
        pixels_sent = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_IN_WIDTH;
        wr_data = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        pix_if.frame_start = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Small frame at unit step with extreme pixels and full gain.
        write_all(3, 3, 3, 3, 32'h10000, 32'h10000, 32'h10000, 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0, 1'b0);
        drain();
        // Negative gain, steps below one that the unit raises to one, frame start left off.
        write_all(3, 3, 4, 4, 32'h8000, 32'h8000, 32'hFFFF0000, 32'h7FFFFFFF);
        for (int i = 0; i < 9; i++)
            send_pixel(8'((i * 97) & 8'hFF), 1'b0, 1'b0);
        drain();
        // Dimensions of zero: one-pixel frames, then an output width of zero and no output at all.
        write_all(0, 0, 1, 1, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        for (int i = 0; i < 4; i++)
            send_pixel(8'(8'hFF - i), i[0], 1'b0);
        drain();
        write_reg(REG_OUT_WIDTH, 0);
        send_pixel(8'h80, 1'b1, 1'b0);
        drain();
        // Widest row with oversized registers, largest vertical step.
        write_all(32'h1FF, 2, 32'h1FF, 32'h1FF, 0, 32'hFFFFFF, 32'h00012345, 32'hFF800000);
        send_frame(1'b0);
        drain();
        // Random phases until the pixel budget is spent.
        while (pixels_sent < 1700)
        begin
            random_config();
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_frame(1'b1);
                send_frame(1'b0);
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_pixel_if.sv
hw/rtl/bdq_result_if.sv
hw/rtl/bdq_quant.sv
hw/rtl/bilinear_downscale_quantize_unit.sv
tb/tb_bilinear_downscale_quantize_unit.sv
